@@ sv/ctmr_pkg.sv @@
// shared types, constants and the digit font for the clock matrix renderer
package ctmr_pkg;

  localparam int CTMR_FRAME_ROWS    = 8;
  localparam int CTMR_FRAME_COLUMNS = 32;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // time rollover limits
  localparam logic [6:0] SEC_LIMIT  = 7'd60;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [5:0] HOUR_LIMIT = 6'd24;
  localparam logic [3:0] WDAY_LIMIT = 4'd7;
  localparam logic [6:0] DAY_TOP    = 7'd127;
  localparam logic [6:0] DIGIT_MAX  = 7'd99;

  // temperature bar
  localparam logic signed [7:0] TEMP_LOW  = -8'sd30;
  localparam logic signed [7:0] TEMP_HIGH = 8'sd50;
  localparam logic [6:0]        TEMP_SPAN = 7'd80;
  localparam int                BAR_LEFT  = 13;
  localparam int                BAR_CELLS = 17;

  // frame layout
  localparam int WDAY_LEFT   = 1;
  localparam int MONTH_LEFT  = 9;
  localparam int DIGIT_TOP   = 2;
  localparam int DAY_LEFT    = 1;
  localparam int HOUR_LEFT   = 13;
  localparam int MIN_LEFT    = 22;
  localparam int DIGIT_PITCH = 4;
  localparam int COLON_LEFT  = 20;
  localparam int COLON_ROW_A = 3;
  localparam int COLON_ROW_B = 5;

  // 3x5 font, bit j of a row is column j from the left
  localparam logic [2:0] GLYPH_ROWS [10][5] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    '{3'd4, 3'd6, 3'd4, 3'd4, 3'd4},
    '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7},
    '{3'd5, 3'd5, 3'd7, 3'd4, 3'd4},
    '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd4, 3'd4, 3'd2, 3'd1},
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd5, 3'd7, 3'd4, 3'd4}
  };

  typedef struct packed {
    logic load;
    logic tick;
    logic emit;
  } ctmr_cmd_t;

  typedef struct packed {
    logic last_row;
  } ctmr_status_t;

  function automatic logic [2:0] glyph_row(logic [3:0] digit, logic [2:0] line);
    logic [2:0] bits;
    bits = 3'd0;
    if (digit <= 4'd9 && line <= 3'd4) begin
      bits = GLYPH_ROWS[digit][line];
    end
    return bits;
  endfunction

endpackage

@@ sv/ctmr_ctrl.sv @@
// sequencer: takes items, steps the row emission and owns the output valid
module ctmr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  op,
  output logic                  row_valid,
  input  logic                  row_ready,
  output ctmr_pkg::ctmr_cmd_t   cmd,
  input  ctmr_pkg::ctmr_status_t status
);
  import ctmr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   row_valid_next;
  logic   item_fire;
  logic   out_free;

  assign item_ready = (state == ST_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign out_free   = !row_valid || row_ready;

  always_comb begin
    cmd.load = item_fire && (op == OP_LOAD);
    cmd.tick = item_fire && (op == OP_TICK);
    cmd.emit = (state == ST_EMIT) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.tick) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.emit && status.last_row) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    row_valid_next = row_valid;
    priority if (cmd.emit) begin
      row_valid_next = 1'b1;
    end else if (row_ready) begin
      row_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row_valid <= row_valid_next;
    end
  end

endmodule

@@ sv/ctmr_datapath.sv @@
// clock registers, tick arithmetic, row drawing and the output register
module ctmr_datapath #(
  parameter int FRAME_ROWS    = ctmr_pkg::CTMR_FRAME_ROWS,
  parameter int FRAME_COLUMNS = ctmr_pkg::CTMR_FRAME_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctmr_pkg::ctmr_cmd_t    cmd,
  output ctmr_pkg::ctmr_status_t status,
  input  logic [5:0]             new_second,
  input  logic [5:0]             new_minute,
  input  logic [4:0]             new_hour,
  input  logic [6:0]             new_day,
  input  logic [2:0]             new_weekday,
  input  logic [3:0]             new_month,
  input  logic signed [7:0]      new_temperature,
  output logic [2:0]             row_index,
  output logic [31:0]            row_pixels,
  output logic                   last
);
  import ctmr_pkg::*;

  localparam int RW = $clog2(FRAME_ROWS);

  logic [5:0]        seconds_count;
  logic [5:0]        minutes_count;
  logic [4:0]        hours_count;
  logic [6:0]        day_count;
  logic [2:0]        weekday_count;
  logic [3:0]        month_num;
  logic signed [7:0] temperature_value;
  logic              colon_phase;
  logic              colon_lit;
  logic [6:0]        day_shown;
  logic              day_drawn;
  logic [RW-1:0]     row_cnt;

  logic [5:0] seconds_next;
  logic [5:0] minutes_next;
  logic [4:0] hours_next;
  logic [6:0] day_next;
  logic [2:0] weekday_next;

  logic [FRAME_COLUMNS-1:0] pix;

  // split a value below 100 into tens and ones, tens by reciprocal of ten
  function automatic logic [7:0] split_digits(logic [6:0] v);
    logic [16:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {10'd0, v} * 17'd103;
    tens = 4'(prod >> 10);
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // tick arithmetic: second step, then rollovers in order
  always_comb begin
    logic [6:0] s_inc;
    logic [6:0] m_inc;
    logic [5:0] h_inc;
    logic [3:0] w_inc;
    s_inc = {1'b0, seconds_count} + {6'd0, colon_phase};
    m_inc = {1'b0, minutes_count};
    h_inc = {1'b0, hours_count};
    w_inc = {1'b0, weekday_count};
    day_next = day_count;
    if (s_inc >= SEC_LIMIT) begin
      s_inc = 7'd0;
      m_inc = m_inc + 7'd1;
    end
    if (m_inc >= MIN_LIMIT) begin
      m_inc = 7'd0;
      h_inc = h_inc + 6'd1;
    end
    if (h_inc >= HOUR_LIMIT) begin
      h_inc = 6'd0;
      if (day_count < DAY_TOP) begin
        day_next = day_count + 7'd1;
      end
      w_inc = w_inc + 4'd1;
    end
    if (w_inc >= WDAY_LIMIT) begin
      w_inc = 4'd0;
    end
    seconds_next = s_inc[5:0];
    minutes_next = m_inc[5:0];
    hours_next   = h_inc[4:0];
    weekday_next = w_inc[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count     <= '0;
      minutes_count     <= '0;
      hours_count       <= '0;
      day_count         <= '0;
      weekday_count     <= '0;
      month_num         <= '0;
      temperature_value <= '0;
      colon_phase       <= 1'b0;
      colon_lit         <= 1'b0;
      day_shown         <= '0;
      day_drawn         <= 1'b0;
      row_cnt           <= '0;
    end else begin
      if (cmd.load) begin
        seconds_count     <= new_second;
        minutes_count     <= new_minute;
        hours_count       <= new_hour;
        day_count         <= new_day;
        weekday_count     <= new_weekday;
        month_num         <= new_month;
        temperature_value <= new_temperature;
      end
      if (cmd.tick) begin
        seconds_count <= seconds_next;
        minutes_count <= minutes_next;
        hours_count   <= hours_next;
        day_count     <= day_next;
        weekday_count <= weekday_next;
        colon_lit     <= colon_phase;
        colon_phase   <= !colon_phase;
        row_cnt       <= '0;
        // day digits above 99 keep whatever was drawn before
        if (day_next <= DIGIT_MAX) begin
          day_shown <= day_next;
          day_drawn <= 1'b1;
        end
      end
      if (cmd.emit) begin
        row_cnt <= row_cnt + RW'(1);
      end
    end
  end

  assign status.last_row = (row_cnt == RW'(FRAME_ROWS - 1));

  // build the pixels of the row under the counter
  always_comb begin
    logic [6:0]  tc;
    logic [14:0] bar_prod;
    logic [4:0]  bar_n;
    logic [3:0]  m_idx;
    logic [3:0]  m_row;
    logic [2:0]  g;
    logic [7:0]  day_d;
    logic [7:0]  hour_d;
    logic [7:0]  min_d;
    pix = '0;

    if (temperature_value < TEMP_LOW) begin
      tc = 7'd0;
    end else if (temperature_value > TEMP_HIGH) begin
      tc = TEMP_SPAN;
    end else begin
      tc = 7'(temperature_value - TEMP_LOW);
    end
    bar_prod = {8'd0, tc} * 15'd205;
    bar_n    = 5'(bar_prod >> 10);

    if (month_num >= 4'd1 && month_num <= 4'd12) begin
      m_idx = month_num - 4'd1;
    end else begin
      m_idx = 4'd0;
    end
    m_row = 4'd1 + {1'b0, m_idx[3:1]};

    g      = 3'(row_cnt - RW'(DIGIT_TOP));
    day_d  = split_digits(day_shown);
    hour_d = split_digits({2'd0, hours_count});
    min_d  = split_digits({1'b0, minutes_count});

    if (row_cnt == RW'(0)) begin
      for (int i = 0; i < 7; i++) begin
        if (weekday_count == 3'(i)) begin
          pix[WDAY_LEFT + i] = 1'b1;
        end
      end
      for (int i = 0; i < BAR_CELLS; i++) begin
        if (5'(i) <= bar_n) begin
          pix[BAR_LEFT + i] = 1'b1;
        end
      end
    end

    if (row_cnt == RW'(m_row)) begin
      pix[MONTH_LEFT + int'(m_idx[0])] = 1'b1;
    end

    if (row_cnt >= RW'(DIGIT_TOP) && row_cnt <= RW'(DIGIT_TOP + 4)) begin
      if (day_drawn) begin
        pix[DAY_LEFT +: 3] = glyph_row(day_d[7:4], g);
        pix[DAY_LEFT + DIGIT_PITCH +: 3] = glyph_row(day_d[3:0], g);
      end
      pix[HOUR_LEFT +: 3] = glyph_row(hour_d[7:4], g);
      pix[HOUR_LEFT + DIGIT_PITCH +: 3] = glyph_row(hour_d[3:0], g);
      pix[MIN_LEFT +: 3] = glyph_row(min_d[7:4], g);
      pix[MIN_LEFT + DIGIT_PITCH +: 3] = glyph_row(min_d[3:0], g);
    end

    if (row_cnt == RW'(COLON_ROW_A) || row_cnt == RW'(COLON_ROW_B)) begin
      pix[COLON_LEFT +: 2] = {colon_lit, colon_lit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_index  <= row_cnt[2:0];
      row_pixels <= pix[31:0];
      last       <= status.last_row;
    end
  end

endmodule

@@ sv/clock_tick_matrix_renderer.sv @@
// top level of the clock matrix renderer: sequencer plus datapath
//
//   channel | handshake              | payload
//   item    | item_valid, item_ready | op, new_second .. new_temperature
//   row     | row_valid, row_ready   | row_index, row_pixels, last
//
// a load item gives no rows
// a tick item first advances the clock, then gives FRAME_ROWS rows, one row a
// cycle while row_ready stays high, counted by the row counter in the datapath
// the next item is taken in the cycle after the last row enters the output register
// rst is synchronous and clears the clock to zero, colon off, day digits hidden
// a stalled row holds in the output register and the row counter waits
module clock_tick_matrix_renderer #(
  parameter int FRAME_ROWS    = ctmr_pkg::CTMR_FRAME_ROWS,
  parameter int FRAME_COLUMNS = ctmr_pkg::CTMR_FRAME_COLUMNS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              op,
  input  logic [5:0]        new_second,
  input  logic [5:0]        new_minute,
  input  logic [4:0]        new_hour,
  input  logic [6:0]        new_day,
  input  logic [2:0]        new_weekday,
  input  logic [3:0]        new_month,
  input  logic signed [7:0] new_temperature,
  output logic              row_valid,
  input  logic              row_ready,
  output logic [2:0]        row_index,
  output logic [31:0]       row_pixels,
  output logic              last
);
  import ctmr_pkg::*;

  ctmr_cmd_t    cmd;
  ctmr_status_t status;

  ctmr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .cmd        (cmd),
    .status     (status)
  );

  ctmr_datapath #(
    .FRAME_ROWS    (FRAME_ROWS),
    .FRAME_COLUMNS (FRAME_COLUMNS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .new_second      (new_second),
    .new_minute      (new_minute),
    .new_hour        (new_hour),
    .new_day         (new_day),
    .new_weekday     (new_weekday),
    .new_month       (new_month),
    .new_temperature (new_temperature),
    .row_index       (row_index),
    .row_pixels      (row_pixels),
    .last            (last)
  );

endmodule

@@ sv/ctmr_checker.sv @@
// port-level checks for the clock matrix renderer, bound to the top level
module ctmr_checker #(
  parameter int FRAME_ROWS = ctmr_pkg::CTMR_FRAME_ROWS
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              op,
  input logic              row_valid,
  input logic              row_ready,
  input logic [2:0]        row_index,
  input logic [31:0]       row_pixels,
  input logic              last
);
  import ctmr_pkg::*;

  // a held row keeps its index and pixels
  assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_ready |=> row_valid && $stable(row_pixels) && $stable(row_index))
    else $error("stalled row changed");

  // the frame end falls on the final row number
  assert property (@(posedge clk) disable iff (rst)
    row_valid && last |-> row_index == 3'(FRAME_ROWS - 1))
    else $error("last flag on wrong row");

  // inside a frame the next row follows at once with the next index
  assert property (@(posedge clk) disable iff (rst)
    row_valid && row_ready && !last |=> row_valid && row_index == 3'($past(row_index) + 3'd1))
    else $error("frame rows not consecutive");

  // a tick transaction blocks further items while its rows go out
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && op == OP_TICK |=> !item_ready)
    else $error("item taken during frame");

  // the bottom row is never drawn on
  assert property (@(posedge clk) disable iff (rst)
    row_valid && row_index == 3'd7 |-> row_pixels == 32'd0)
    else $error("bottom row lit");

endmodule

bind clock_tick_matrix_renderer ctmr_checker #(.FRAME_ROWS(FRAME_ROWS)) u_ctmr_checker (.*);

@@ bench/ctmr_frame_checker.sv @@
// frame row checker for the clock matrix renderer: predicts every row and compares
module ctmr_frame_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  logic              op,
  input  logic [5:0]        new_second,
  input  logic [5:0]        new_minute,
  input  logic [4:0]        new_hour,
  input  logic [6:0]        new_day,
  input  logic [2:0]        new_weekday,
  input  logic [3:0]        new_month,
  input  logic signed [7:0] new_temperature,
  input  logic              row_valid,
  input  logic              row_ready,
  input  logic [2:0]        row_index,
  input  logic [31:0]       row_pixels,
  input  logic              last,
  output int                mismatches,
  output int                rows_pending
);
  import ctmr_pkg::*;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] pixels;
    logic        last_row;
  } frame_row_t;

  // counters but day_cnt are 1 bit wider than the ports so loaded values past limits roll
  logic [6:0]        sec_cnt;
  logic [6:0]        min_cnt;
  logic [5:0]        hour_cnt;
  logic [6:0]        day_cnt;
  logic [3:0]        wday_cnt;
  logic [3:0]        month_val;
  logic signed [7:0] temp_val;
  logic              colon_on;
  logic [31:0]       frame [8];
  frame_row_t        pending_rows [$];

  // rows of a 3x5 digit, top row in the low bits, bit j is column j from the left
  function automatic logic [14:0] digit_bitmap(input logic [3:0] d);
    case (d)
      4'd0:    return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    return {3'd4, 3'd4, 3'd4, 3'd6, 3'd4};
      4'd2:    return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    return {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
      4'd4:    return {3'd4, 3'd4, 3'd7, 3'd5, 3'd5};
      4'd5:    return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    return {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      4'd7:    return {3'd1, 3'd2, 3'd4, 3'd4, 3'd7};
      4'd8:    return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    return {3'd4, 3'd4, 3'd7, 3'd5, 3'd7};
      default: return 15'd0;
    endcase
  endfunction

  function automatic void set_pixel(input int x, input int y, input logic on);
    if (x >= 0 && x < 32 && y >= 0 && y < 8) begin
      frame[y][x] = on;
    end
  endfunction

  function automatic void draw_digit(input int top, input int left, input logic [3:0] d);
    logic [14:0] bm;
    bm = digit_bitmap(d);
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 3; j++) begin
        set_pixel(left + j, top + i, bm[3 * i + j]);
      end
    end
  endfunction

  // values past two digits leave whatever was drawn before
  function automatic void draw_value(input int top, input int left, input logic [6:0] v);
    if (v <= 7'd99) begin
      draw_digit(top, left, 4'(v / 7'd10));
      draw_digit(top, left + 4, 4'(v % 7'd10));
    end
  endfunction

  function automatic void advance_and_redraw();
    int shown_month;
    int t;
    int bar;
    if (colon_on) sec_cnt++;
    if (sec_cnt >= 7'd60) begin
      sec_cnt = 7'd0;
      min_cnt++;
    end
    if (min_cnt >= 7'd60) begin
      min_cnt = 7'd0;
      hour_cnt++;
    end
    if (hour_cnt >= 6'd24) begin
      hour_cnt = 6'd0;
      if (day_cnt < 7'd127) day_cnt++;
      wday_cnt++;
    end
    if (wday_cnt >= 4'd7) wday_cnt = 4'd0;

    // colon shows the phase from before the toggle
    set_pixel(20, 3, colon_on);
    set_pixel(20, 5, colon_on);
    set_pixel(21, 3, colon_on);
    set_pixel(21, 5, colon_on);
    colon_on = !colon_on;

    shown_month = (month_val < 4'd1 || month_val > 4'd12) ? 1 : int'(month_val);
    for (int i = 0; i < 6; i++) begin
      set_pixel(9, 1 + i, 1'b0);
      set_pixel(10, 1 + i, 1'b0);
    end
    set_pixel(9 + (shown_month - 1) % 2, 1 + (shown_month - 1) / 2, 1'b1);

    draw_value(2, 1, day_cnt);

    frame[0] = 32'd0;
    for (int i = 0; i < 7; i++) begin
      set_pixel(1 + i, 0, wday_cnt == i);
    end

    draw_value(2, 13, 7'(hour_cnt));
    draw_value(2, 22, min_cnt);

    t = temp_val;
    if (t < -30) t = -30;
    if (t > 50) t = 50;
    bar = (t + 30) / 5 + 1;
    for (int i = 0; i < bar; i++) begin
      set_pixel(13 + i, 0, 1'b1);
    end

    for (int k = 0; k < 8; k++) begin
      pending_rows.push_back('{index: 3'(k), pixels: frame[k], last_row: k == 7});
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    frame_row_t want;
    if (rst) begin
      sec_cnt    = 7'd0;
      min_cnt    = 7'd0;
      hour_cnt   = 6'd0;
      day_cnt    = 7'd0;
      wday_cnt   = 4'd0;
      month_val  = 4'd0;
      temp_val   = 8'sd0;
      colon_on   = 1'b0;
      mismatches = 0;
      for (int k = 0; k < 8; k++) frame[k] = 32'd0;
      pending_rows.delete();
    end else begin
      // a row transaction always belongs to an earlier item, so compare before predicting
      if (row_valid && row_ready) begin
        if (pending_rows.size() == 0) begin
          $error("row transaction with nothing expected: row_index %0d row_pixels %h",
                 row_index, row_pixels);
          mismatches++;
        end else begin
          want = pending_rows.pop_front();
          if (row_index !== want.index) begin
            $error("row_index mismatch: expected %0d, actual %0d", want.index, row_index);
            mismatches++;
          end
          if (row_pixels !== want.pixels) begin
            $error("row_pixels mismatch: expected %h, actual %h", want.pixels, row_pixels);
            mismatches++;
          end
          if (last !== want.last_row) begin
            $error("last mismatch: expected %0b, actual %0b", want.last_row, last);
            mismatches++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (op == OP_LOAD) begin
          sec_cnt   = {1'b0, new_second};
          min_cnt   = {1'b0, new_minute};
          hour_cnt  = {1'b0, new_hour};
          day_cnt   = new_day;
          wday_cnt  = {1'b0, new_weekday};
          month_val = new_month;
          temp_val  = new_temperature;
        end else begin
          advance_and_redraw();
        end
      end
    end
    rows_pending = pending_rows.size();
  end

endmodule

@@ bench/clock_tick_matrix_renderer_tb.sv @@
// testbench top for the clock matrix renderer: stimulus, receiver pacing and verdict
module clock_tick_matrix_renderer_tb;
  import ctmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic              op = OP_TICK;
  logic [5:0]        new_second = '0;
  logic [5:0]        new_minute = '0;
  logic [4:0]        new_hour = '0;
  logic [6:0]        new_day = '0;
  logic [2:0]        new_weekday = '0;
  logic [3:0]        new_month = '0;
  logic signed [7:0] new_temperature = '0;
  logic              row_valid;
  logic              row_ready = 1'b0;
  logic [2:0]        row_index;
  logic [31:0]       row_pixels;
  logic              last;

  int   mismatches;
  int   rows_pending;
  int   send_idle_pct = 18;
  int   recv_idle_pct = 74;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  clock_tick_matrix_renderer dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .op              (op),
    .new_second      (new_second),
    .new_minute      (new_minute),
    .new_hour        (new_hour),
    .new_day         (new_day),
    .new_weekday     (new_weekday),
    .new_month       (new_month),
    .new_temperature (new_temperature),
    .row_valid       (row_valid),
    .row_ready       (row_ready),
    .row_index       (row_index),
    .row_pixels      (row_pixels),
    .last            (last)
  );

  ctmr_frame_checker frame_check (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .op              (op),
    .new_second      (new_second),
    .new_minute      (new_minute),
    .new_hour        (new_hour),
    .new_day         (new_day),
    .new_weekday     (new_weekday),
    .new_month       (new_month),
    .new_temperature (new_temperature),
    .row_valid       (row_valid),
    .row_ready       (row_ready),
    .row_index       (row_index),
    .row_pixels      (row_pixels),
    .last            (last),
    .mismatches      (mismatches),
    .rows_pending    (rows_pending)
  );

  // receiver pacing, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      row_ready <= 1'b0;
    end else begin
      row_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (row_valid && row_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic o, input logic [5:0] s, input logic [5:0] mi,
                           input logic [4:0] h, input logic [6:0] d, input logic [2:0] w,
                           input logic [3:0] mo, input logic signed [7:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid      <= 1'b1;
    op              <= o;
    new_second      <= s;
    new_minute      <= mi;
    new_hour        <= h;
    new_day         <= d;
    new_weekday     <= w;
    new_month       <= mo;
    new_temperature <= t;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // the load fields carry noise on a tick
  task automatic send_tick();
    send_item(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
              3'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic drain_rows();
    item_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // mostly a load near the rollover edges followed by a run of ticks
  task automatic random_scene();
    int                shape;
    logic [5:0]        s;
    logic [5:0]        mi;
    logic [4:0]        h;
    logic [6:0]        d;
    logic signed [7:0] t;
    shape = $urandom_range(99);
    if (shape < 70) begin
      if ($urandom_range(1) == 0) s = 6'($urandom_range(63, 56));
      else s = 6'($urandom_range(63));
      case ($urandom_range(2))
        0:       mi = 6'd59;
        1:       mi = 6'($urandom_range(63, 56));
        default: mi = 6'($urandom_range(63));
      endcase
      if ($urandom_range(1) == 0) h = 5'($urandom_range(31, 22));
      else h = 5'($urandom_range(31));
      case ($urandom_range(3))
        0:       d = 7'($urandom_range(127));
        1:       d = 7'($urandom_range(101, 97));
        2:       d = 7'($urandom_range(127, 124));
        default: d = 7'($urandom_range(31, 1));
      endcase
      if ($urandom_range(1) == 0) t = 8'($urandom);
      else t = 8'($urandom_range(90) - 35);
      send_item(OP_LOAD, s, mi, h, d, 3'($urandom_range(7)), 4'($urandom_range(15)), t);
      repeat ($urandom_range(6, 1)) send_tick();
    end else if (shape < 85) begin
      repeat ($urandom_range(4, 1)) send_tick();
    end else begin
      send_item(OP_LOAD, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                3'($urandom), 4'($urandom), 8'($urandom));
      if ($urandom_range(1) == 0) send_tick();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first frames after reset, month zero shown as january, then the colon lights
    send_tick();
    send_tick();
    // everything at the top: all counters roll, day stuck at the top, weekday wraps
    send_item(OP_LOAD, 6'd63, 6'd63, 5'd31, 7'd127, 3'd7, 4'd15, 8'sd127);
    send_tick();
    // all zero with the coldest temperature
    send_item(OP_LOAD, 6'd0, 6'd0, 5'd0, 7'd0, 3'd0, 4'd0, -8'sd128);
    send_tick();
    // end of the day, day goes past two digits on the second tick
    send_item(OP_LOAD, 6'd59, 6'd59, 5'd23, 7'd99, 3'd6, 4'd12, 8'sd50);
    send_tick();
    send_tick();
    // weekday seven without rollover, month past december
    send_item(OP_LOAD, 6'd30, 6'd5, 5'd9, 7'd7, 3'd7, 4'd13, -8'sd31);
    send_tick();
    // three-digit day leaves the old digits
    send_item(OP_LOAD, 6'd0, 6'd0, 5'd0, 7'd100, 3'd3, 4'd2, 8'sd51);
    send_tick();
    send_item(OP_LOAD, 6'd10, 6'd10, 5'd10, 7'd10, 3'd5, 4'd11, -8'sd30);
    send_tick();
    send_item(OP_LOAD, 6'd42, 6'd21, 5'd18, 7'd31, 3'd1, 4'd1, 8'sd49);
    send_tick();
    send_tick();
    // out-of-range minute and hour on their own
    send_item(OP_LOAD, 6'd1, 6'd61, 5'd26, 7'd64, 3'd4, 4'd6, 8'sd0);
    send_tick();

    while (items_sent < 90) random_scene();
    drain_rows();

    send_idle_pct = 74;
    recv_idle_pct = 18;
    while (items_sent < 150) random_scene();
    drain_rows();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver stops for a long stretch while ticks keep coming
    hold_request <= 1'b1;
    repeat (6) send_tick();
    while (items_sent < 210) random_scene();

    drain_rows();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
